FILE: sv/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants for the homogeneous point transform block.
// ----------------------------------------------------------------------------
package hpt_pkg;

    typedef enum logic [1:0] {
        MODE_2D_AFFINE = 2'd0,
        MODE_3D_AFFINE = 2'd1,
        MODE_4D        = 2'd2,
        MODE_3D_PROJ   = 2'd3
    } t_mode;

    localparam logic ACT_LOAD      = 1'b0;
    localparam logic ACT_TRANSFORM = 1'b1;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam int NUM_LANES = 4;
    localparam int NUM_DIVS  = 3;

endpackage

FILE: sv/hpt_if.sv
// ----------------------------------------------------------------------------
// hpt_in_if / hpt_out_if
// Valid/ready channels carrying the input and result words of the block.
// ----------------------------------------------------------------------------
interface hpt_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic [1:0]         mode;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;

    modport source  (output valid, action, coef_index, coef_value, mode,
                     in_x, in_y, in_z, in_w, input ready);
    modport sink    (input valid, action, coef_index, coef_value, mode,
                     in_x, in_y, in_z, in_w, output ready);
    modport monitor (input valid, ready, action, coef_index, coef_value, mode,
                     in_x, in_y, in_z, in_w);
endinterface

interface hpt_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               saturated;
    logic               divide_by_zero;

    modport source  (output valid, out_x, out_y, out_z, out_w, saturated,
                     divide_by_zero, input ready);
    modport sink    (input valid, out_x, out_y, out_z, out_w, saturated,
                     divide_by_zero, output ready);
    modport monitor (input valid, ready, out_x, out_y, out_z, out_w, saturated,
                     divide_by_zero);
endinterface

FILE: sv/hpt_lane.sv
// ----------------------------------------------------------------------------
// hpt_lane
// One matrix column: four registered products, then sum, shift and saturate.
// ----------------------------------------------------------------------------
module hpt_lane
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_vec  [4],
    input  logic signed [31:0] i_coef [4],
    output logic signed [31:0] o_res,
    output logic               o_sat
);

    localparam logic signed [65:0] MAXV = 66'(S32_MAX);
    localparam logic signed [65:0] MINV = 66'(S32_MIN);

    logic signed [63:0] r_prod [4];
    logic signed [65:0] w_sum;
    logic signed [65:0] w_sh;
    logic signed [31:0] n_res;
    logic               n_sat;
    logic signed [31:0] r_res;
    logic               r_sat;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                r_prod[r] <= i_vec[r] * i_coef[r];
            end
            r_res <= n_res;
            r_sat <= n_sat;
        end
    end

    always_comb begin
        w_sum = 66'(r_prod[0]) + 66'(r_prod[1]) + 66'(r_prod[2]) + 66'(r_prod[3]);
        w_sh  = w_sum >>> FRAC_BITS;
        n_sat = 1'b0;
        n_res = w_sh[31:0];
        if (w_sh > MAXV) begin
            n_sat = 1'b1;
            n_res = S32_MAX;
        end else if (w_sh < MINV) begin
            n_sat = 1'b1;
            n_res = S32_MIN;
        end
    end

    assign o_res = r_res;
    assign o_sat = r_sat;

endmodule

FILE: sv/hpt_div.sv
// ----------------------------------------------------------------------------
// hpt_div
// Pipelined restoring divider: |num| << FRAC_BITS over |den|, one bit a stage.
// ----------------------------------------------------------------------------
module hpt_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [31:0]      i_num,
    input  logic signed [31:0]      i_den,
    output logic [32+FRAC_BITS-1:0] o_quo
);

    localparam int QW = 32 + FRAC_BITS;

    logic [31:0]   r_rem [QW];
    logic [QW-1:0] r_dq  [QW];
    logic [31:0]   r_den [QW];

    logic [31:0]   w_srem [QW];
    logic [QW-1:0] w_sdq  [QW];
    logic [31:0]   w_sden [QW];
    logic [31:0]   w_nrem [QW];
    logic [QW-1:0] w_ndq  [QW];
    logic [31:0]   w_a;
    logic [32:0]   w_t    [QW];
    logic          w_ge   [QW];

    always_comb begin
        // Magnitudes; the negation of the most negative value wraps to 2^31.
        w_a       = i_num[31] ? 32'(-i_num) : i_num;
        w_srem[0] = '0;
        w_sdq[0]  = {w_a, {FRAC_BITS{1'b0}}};
        w_sden[0] = i_den[31] ? 32'(-i_den) : i_den;
        for (int k = 1; k < QW; k++) begin
            w_srem[k] = r_rem[k-1];
            w_sdq[k]  = r_dq[k-1];
            w_sden[k] = r_den[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            w_t[k]    = {w_srem[k], w_sdq[k][QW-1]};
            w_ge[k]   = w_t[k] >= {1'b0, w_sden[k]};
            w_nrem[k] = w_ge[k] ? 32'(w_t[k] - {1'b0, w_sden[k]}) : w_t[k][31:0];
            w_ndq[k]  = {w_sdq[k][QW-2:0], w_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= w_nrem[k];
                r_dq[k]  <= w_ndq[k];
                r_den[k] <= w_sden[k];
            end
        end
    end

    assign o_quo = r_dq[QW-1];

endmodule

FILE: sv/homogeneous_point_transform_top.sv
// ----------------------------------------------------------------------------
// homogeneous_point_transform_top
// 4x4 fixed-point vertex transform with optional perspective divide.
// ----------------------------------------------------------------------------
// Accepts one word per cycle when the output side is not stalled. A load word
// writes one matrix coefficient at once and yields no result; a transform word
// yields one result, in every mode, through the product and result registers
// of the four column lanes, the bit-per-stage dividers and one output
// register. The whole pipeline advances together and stalls only while the
// output register holds an untaken result. A load word that follows a
// transform word does not affect the transform already in flight.
module homogeneous_point_transform_top
    import hpt_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hpt_in_if.sink     i_in,
    hpt_out_if.source  o_out
);

    localparam int QW = 32 + FRAC_BITS;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] w;
        logic [3:0]         sat;
    } t_side;

    logic               w_en;
    logic               w_acc;
    logic signed [31:0] r_mat [16];
    logic signed [31:0] w_vec [4];
    logic signed [31:0] w_coef [NUM_LANES][4];
    logic signed [31:0] w_res [NUM_LANES];
    logic               w_lsat [NUM_LANES];
    logic [QW-1:0]      w_quo [NUM_DIVS];
    logic signed [31:0] w_num [NUM_DIVS];

    logic               r_v1, r_v2;
    logic [1:0]         r_mode1, r_mode2;
    logic               r_sv   [QW];
    t_side              r_side [QW];
    t_side              w_side0;
    t_side              w_tail;

    logic               r_ov;
    logic signed [31:0] r_ox, r_oy, r_oz, r_ow;
    logic               r_osat, r_odbz;
    logic signed [31:0] n_ox, n_oy, n_oz, n_ow;
    logic               n_osat, n_odbz;
    logic signed [31:0] w_qres [NUM_DIVS];
    logic               w_qsat [NUM_DIVS];
    logic               w_neg  [NUM_DIVS];
    logic signed [31:0] w_tv   [NUM_DIVS];

    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;
    assign w_acc      = i_in.valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i % 5 == 0) ? ONE : '0;
            end
        end else if (w_acc && i_in.action == ACT_LOAD) begin
            r_mat[i_in.coef_index] <= i_in.coef_value;
        end
    end

    always_comb begin
        w_vec[0] = i_in.in_x;
        w_vec[1] = i_in.in_y;
        w_vec[2] = (t_mode'(i_in.mode) == MODE_2D_AFFINE) ? '0 : i_in.in_z;
        w_vec[3] = (t_mode'(i_in.mode) == MODE_4D) ? i_in.in_w : ONE;
        for (int c = 0; c < NUM_LANES; c++) begin
            for (int r = 0; r < 4; r++) begin
                w_coef[c][r] = r_mat[r*4 + c];
            end
        end
    end

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        hpt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_vec  (w_vec),
            .i_coef (w_coef[c]),
            .o_res  (w_res[c]),
            .o_sat  (w_lsat[c])
        );
    end

    assign w_num[0] = w_res[0];
    assign w_num[1] = w_res[1];
    assign w_num[2] = w_res[2];

    for (genvar d = 0; d < NUM_DIVS; d++) begin : g_div
        hpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (w_num[d]),
            .i_den (w_res[3]),
            .o_quo (w_quo[d])
        );
    end

    always_comb begin
        w_side0.mode = r_mode2;
        w_side0.x    = w_res[0];
        w_side0.y    = w_res[1];
        w_side0.z    = w_res[2];
        w_side0.w    = w_res[3];
        w_side0.sat  = {w_lsat[3], w_lsat[2], w_lsat[1], w_lsat[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k < QW; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_v1    <= w_acc && (i_in.action == ACT_TRANSFORM);
            r_v2    <= r_v1;
            r_sv[0] <= r_v2;
            for (int k = 1; k < QW; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r_ov <= r_sv[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mode1   <= i_in.mode;
            r_mode2   <= r_mode1;
            r_side[0] <= w_side0;
            for (int k = 1; k < QW; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_ox   <= n_ox;
            r_oy   <= n_oy;
            r_oz   <= n_oz;
            r_ow   <= n_ow;
            r_osat <= n_osat;
            r_odbz <= n_odbz;
        end
    end

    // Merge stage: select per mode and saturate the quotients.
    always_comb begin
        w_tail  = r_side[QW-1];
        w_tv[0] = w_tail.x;
        w_tv[1] = w_tail.y;
        w_tv[2] = w_tail.z;
        for (int d = 0; d < NUM_DIVS; d++) begin
            w_neg[d]  = w_tv[d][31] ^ w_tail.w[31];
            w_qsat[d] = 1'b0;
            w_qres[d] = w_quo[d][31:0];
            if (!w_neg[d]) begin
                if (w_quo[d] > {{(QW-31){1'b0}}, 31'h7FFF_FFFF}) begin
                    w_qsat[d] = 1'b1;
                    w_qres[d] = S32_MAX;
                end
            end else begin
                if (w_quo[d] > {{(QW-32){1'b0}}, 32'h8000_0000}) begin
                    w_qsat[d] = 1'b1;
                    w_qres[d] = S32_MIN;
                end else begin
                    w_qres[d] = -w_quo[d][31:0];
                end
            end
        end

        n_ox   = w_tail.x;
        n_oy   = w_tail.y;
        n_oz   = w_tail.z;
        n_ow   = ONE;
        n_osat = |w_tail.sat;
        n_odbz = 1'b0;
        unique case (t_mode'(w_tail.mode))
            MODE_2D_AFFINE: begin
                n_oz   = '0;
                n_osat = w_tail.sat[0] | w_tail.sat[1];
            end
            MODE_3D_AFFINE: begin
                n_osat = |w_tail.sat[2:0];
            end
            MODE_4D: begin
                n_ow = w_tail.w;
            end
            MODE_3D_PROJ: begin
                if (w_tail.w == '0) begin
                    n_ox   = '0;
                    n_oy   = '0;
                    n_oz   = '0;
                    n_odbz = 1'b1;
                end else begin
                    n_ox   = w_qres[0];
                    n_oy   = w_qres[1];
                    n_oz   = w_qres[2];
                    n_osat = (|w_tail.sat) | w_qsat[0] | w_qsat[1] | w_qsat[2];
                end
            end
            default: begin
                n_ow = ONE;
            end
        endcase
    end

    assign o_out.valid          = r_ov;
    assign o_out.out_x          = r_ox;
    assign o_out.out_y          = r_oy;
    assign o_out.out_z          = r_oz;
    assign o_out.out_w          = r_ow;
    assign o_out.saturated      = r_osat;
    assign o_out.divide_by_zero = r_odbz;

    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.divide_by_zero |->
            o_out.out_x == '0 && o_out.out_y == '0 && o_out.out_z == '0 &&
            o_out.out_w == ONE)
        else $error("divide-by-zero result is not zeroed");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready && i_in.action == ACT_LOAD |=> !r_v1)
        else $error("load word entered the result pipeline");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule
